// ===== sv/multi_channel_beep_pattern_generator_defines.svh =====
// Assertion macros for the beep pattern generator.
`ifndef MULTI_CHANNEL_BEEP_PATTERN_GENERATOR_DEFINES_SVH
`define MULTI_CHANNEL_BEEP_PATTERN_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define MCBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define MCBP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `MCBP_ASSERT(label, clk, rst, !(expr), msg)

`else

`define MCBP_ASSERT(label, clk, rst, prop, msg)
`define MCBP_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== sv/mcbp_pkg.sv =====
// Package: widths, operation codes and constants of the beep pattern generator.
`default_nettype none

package mcbp_pkg;

   localparam int NUM_CHANNELS_DEF = 8;

   localparam int OP_W    = 2;
   localparam int CHAN_W  = 3;
   localparam int COUNT_W = 8;
   localparam int MASK_W  = 8;
   localparam int CSR_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_TICK = 2'd0,
      OP_RING = 2'd1,
      OP_STOP = 2'd2
   } op_type;

   localparam logic [COUNT_W-1:0] COUNT_PRESET  = 8'hFE;
   localparam logic [COUNT_W-1:0] FOREVER_LIMIT = 8'd100;
   localparam logic [COUNT_W-1:0] RING_FOREVER  = 8'hFF;
   localparam logic [CSR_W-1:0]   ACTIVE_RESET  = 4'd8;

endpackage

`default_nettype wire

// ===== sv/mcbp_channels.sv =====
// Handshake interfaces: command channel, result channel and register write channel.
`default_nettype none

interface mcbp_req_if import mcbp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [CHAN_W-1:0]  channel;
   logic [COUNT_W-1:0] repeat_count;
   logic [COUNT_W-1:0] high_ticks;
   logic [COUNT_W-1:0] low_ticks;

   modport source (output valid, operation, channel, repeat_count, high_ticks, low_ticks,
                   input ready);
   modport sink   (input valid, operation, channel, repeat_count, high_ticks, low_ticks,
                   output ready);
endinterface

interface mcbp_rsp_if import mcbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] level_mask;
   logic [MASK_W-1:0] driven_mask;
   logic [MASK_W-1:0] finished_mask;

   modport source (output valid, level_mask, driven_mask, finished_mask, input ready);
   modport sink   (input valid, level_mask, driven_mask, finished_mask, output ready);
endinterface

interface mcbp_csr_if import mcbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/multi_channel_beep_pattern_generator.sv =====
// Top level of the multi-channel buzzer beep pattern generator.
`default_nettype none

// Drives NUM_CHANNELS buzzer channels with on/off beep patterns. For each command item
// (tick, ring one channel, stop all) all channels update in parallel in a single
// pass of per-channel logic (an 8-bit increment and compare each) straight into
// the channel state and the result register, so one item is accepted every cycle
// as long as the result register is empty or its item is taken in the same cycle.
// Each item yields exactly one result item, valid from the next cycle on.
// The active_channels register (csr_ channel, always ready) limits which
// channels tick and stop serve; values above NUM_CHANNELS act as NUM_CHANNELS.
// Write it only while the block is idle. Reset clears level, counter and toggle
// count of every channel at once; there is no clearing pass. The stored periods
// are not reset: they are only read by a running channel, which a ring has
// loaded first. Only channels 0..7 show in the 8-bit result masks.

`include "multi_channel_beep_pattern_generator_defines.svh"

module multi_channel_beep_pattern_generator import mcbp_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   mcbp_req_if.sink   req_bus,
   mcbp_rsp_if.source rsp_bus,
   mcbp_csr_if.sink   csr_bus
);

   // served-channel count register
   logic [CSR_W-1:0] active_ff;

   // per-channel state
   logic [NUM_CHANNELS-1:0] level_ff, level_in;
   logic [COUNT_W-1:0]      tick_ff   [NUM_CHANNELS];
   logic [COUNT_W-1:0]      tick_in   [NUM_CHANNELS];
   logic [COUNT_W-1:0]      tog_ff    [NUM_CHANNELS];
   logic [COUNT_W-1:0]      tog_in    [NUM_CHANNELS];
   logic [COUNT_W-1:0]      on_ff     [NUM_CHANNELS];
   logic [COUNT_W-1:0]      on_in     [NUM_CHANNELS];
   logic [COUNT_W-1:0]      off_ff    [NUM_CHANNELS];
   logic [COUNT_W-1:0]      off_in    [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] drv_vec, fin_vec;

   // result register
   logic              rsp_valid_ff;
   logic [MASK_W-1:0] level_mask_ff, driven_ff, finished_ff;
   logic [MASK_W-1:0] level_mask_in, driven_in, finished_in;

   logic              req_acc;
   logic [COUNT_W-1:0] ring_toggles;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_acc       = req_bus.valid && req_bus.ready;

   // above the limit the channel rings forever, else two toggles per beep
   assign ring_toggles = (req_bus.repeat_count > FOREVER_LIMIT) ? RING_FOREVER :
                         {req_bus.repeat_count[COUNT_W-2:0], 1'b0};

   always_comb begin
      logic [COUNT_W-1:0] cnt;
      logic [COUNT_W-1:0] per;
      logic               served;
      logic               hit;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         cnt        = tick_ff[i] + 8'd1;
         per        = level_ff[i] ? on_ff[i] : off_ff[i];
         served     = 6'(i) < 6'(active_ff);
         hit        = 6'(req_bus.channel) == 6'(i);
         level_in[i] = level_ff[i];
         tick_in[i]  = tick_ff[i];
         tog_in[i]   = tog_ff[i];
         on_in[i]    = on_ff[i];
         off_in[i]   = off_ff[i];
         drv_vec[i]  = 1'b0;
         fin_vec[i]  = 1'b0;
         if (req_acc) begin
            case (req_bus.operation)
               OP_TICK: begin
                  if (served && tog_ff[i] != 8'd0) begin
                     if (cnt > per) begin
                        // phase over: flip level, count one toggle
                        tick_in[i]  = 8'd0;
                        level_in[i] = ~level_ff[i];
                        drv_vec[i]  = 1'b1;
                        if (tog_ff[i] != RING_FOREVER) begin
                           tog_in[i]  = tog_ff[i] - 8'd1;
                           fin_vec[i] = tog_ff[i] == 8'd1;
                        end
                     end else begin
                        tick_in[i] = cnt;
                     end
                  end
               end
               OP_RING: begin
                  if (hit) begin
                     level_in[i] = 1'b0;
                     tick_in[i]  = COUNT_PRESET;
                     tog_in[i]   = ring_toggles;
                     on_in[i]    = req_bus.high_ticks;
                     off_in[i]   = req_bus.low_ticks;
                     drv_vec[i]  = 1'b1;
                  end
               end
               OP_STOP: begin
                  // periods are kept
                  if (served) begin
                     level_in[i] = 1'b0;
                     tick_in[i]  = 8'd0;
                     tog_in[i]   = 8'd0;
                     drv_vec[i]  = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // only channels 0..7 are visible in the masks
   for (genvar g = 0; g < MASK_W; g++) begin : g_mask
      if (g < NUM_CHANNELS) begin : g_vis
         assign level_mask_in[g] = level_in[g];
         assign driven_in[g]     = drv_vec[g];
         assign finished_in[g]   = fin_vec[g];
      end else begin : g_hid
         assign level_mask_in[g] = 1'b0;
         assign driven_in[g]     = 1'b0;
         assign finished_in[g]   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         active_ff <= csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            tick_ff[i] <= '0;
            tog_ff[i]  <= '0;
         end
      end else begin
         level_ff <= level_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            tick_ff[i] <= tick_in[i];
            tog_ff[i]  <= tog_in[i];
         end
      end
   end

   // periods are read only after a ring has loaded them
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         on_ff[i]  <= on_in[i];
         off_ff[i] <= off_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         rsp_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         level_mask_ff <= level_mask_in;
         driven_ff     <= driven_in;
         finished_ff   <= finished_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.level_mask    = level_mask_ff;
   assign rsp_bus.driven_mask   = driven_ff;
   assign rsp_bus.finished_mask = finished_ff;

   `MCBP_ASSERT(a_fin_driven, clock, reset, rsp_valid_ff |-> ((finished_ff & ~driven_ff) == 8'h00), "finished channel did not toggle")
   `MCBP_ASSERT(a_nontick_nofin, clock, reset, (req_acc && req_bus.operation != OP_TICK) |=> (finished_ff == 8'h00), "finish flagged outside tick")
   `MCBP_ASSERT(a_stop_off, clock, reset, (req_acc && req_bus.operation == OP_STOP) |=> ((level_mask_ff & driven_ff) == 8'h00), "stopped channel left on")
   `MCBP_ASSERT(a_ring_one, clock, reset, (req_acc && req_bus.operation == OP_RING) |=> $onehot0(driven_ff), "ring drove several channels")
   `MCBP_ASSERT_NEVER(a_empty_ready, clock, reset, !rsp_valid_ff && !req_bus.ready, "stalled with empty result register")

endmodule

`default_nettype wire

// ===== sim/multi_channel_beep_pattern_generator_tb.sv =====
// Self-checking testbench for the multi-channel buzzer beep pattern generator.
`timescale 1ns / 100ps

module multi_channel_beep_pattern_generator_tb import mcbp_pkg::*; ();

   localparam int CLK_PERIOD = 12;
   localparam int NCH = NUM_CHANNELS_DEF;
   // watchdog: far beyond the slowest legal run (every item stalled on both sides)
   localparam int WATCHDOG_CYCLES = 300_000;
   // drain guard: one item of latency plus stalls, with plenty of margin
   localparam int DRAIN_LIMIT = 2_000;
   localparam int MAX_PRINTED = 20;
   // operation code 3 is not defined; the block must ignore it
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [CHAN_W-1:0]  chan;
      logic [COUNT_W-1:0] reps;
      logic [COUNT_W-1:0] hi;
      logic [COUNT_W-1:0] lo;
   } beep_cmd_type;

   typedef struct packed {
      logic [MASK_W-1:0] level;
      logic [MASK_W-1:0] driven;
      logic [MASK_W-1:0] finished;
   } beep_masks_type;

   logic clock;
   logic reset;

   mcbp_req_if req_bus ();
   mcbp_rsp_if rsp_bus ();
   mcbp_csr_if csr_bus ();

   multi_channel_beep_pattern_generator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the channel state, advanced once per accepted item
   // ---------------------------------------------------------------------
   logic [NCH-1:0]     ch_level;
   logic [COUNT_W-1:0] ch_count   [NCH];
   logic [COUNT_W-1:0] ch_toggles [NCH];
   logic [COUNT_W-1:0] ch_on      [NCH];
   logic [COUNT_W-1:0] ch_off     [NCH];
   logic [CSR_W-1:0]   served_reg;

   beep_masks_type expected_masks [$];

   int  mismatch_count  = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  rings_sent      = 0;
   int  forever_rings   = 0;
   int  finishes_seen   = 0;
   bit  jitter_on       = 1'b0;

   function automatic void clear_channels();
      ch_level = '0;
      for (int ch = 0; ch < NCH; ch++) begin
         ch_count[ch]   = '0;
         ch_toggles[ch] = '0;
         ch_on[ch]      = '0;
         ch_off[ch]     = '0;
      end
      served_reg = ACTIVE_RESET;
   endfunction

   // Applies one command item to the shadow state and returns the masks the
   // block must report for it.
   function automatic beep_masks_type advance_channels(input beep_cmd_type c);
      beep_masks_type m;
      int n;
      logic [COUNT_W-1:0] period;
      m = '0;
      // register values above the channel count act as the channel count
      n = (served_reg > NCH) ? NCH : int'(served_reg);
      case (c.op)
         OP_TICK: begin
            for (int ch = 0; ch < n; ch++) begin
               if (ch_toggles[ch] != '0) begin
                  // 8-bit counter wraps; with period 255 it never exceeds it
                  ch_count[ch] = ch_count[ch] + 1'b1;
                  period = ch_level[ch] ? ch_on[ch] : ch_off[ch];
                  if (ch_count[ch] > period) begin
                     ch_count[ch]  = '0;
                     ch_level[ch]  = ~ch_level[ch];
                     m.driven[ch]  = 1'b1;
                     if (ch_toggles[ch] != RING_FOREVER) begin
                        ch_toggles[ch] = ch_toggles[ch] - 1'b1;
                        if (ch_toggles[ch] == '0)
                           m.finished[ch] = 1'b1;
                     end
                  end
               end
            end
         end
         OP_RING: begin
            // loads even channels beyond the served range
            if (c.chan < NCH) begin
               ch_level[c.chan]   = 1'b0;
               ch_count[c.chan]   = COUNT_PRESET;
               ch_toggles[c.chan] = (c.reps > FOREVER_LIMIT) ? RING_FOREVER : (c.reps << 1);
               ch_on[c.chan]      = c.hi;
               ch_off[c.chan]     = c.lo;
               m.driven[c.chan]   = 1'b1;
            end
         end
         OP_STOP: begin
            // periods survive a stop
            for (int ch = 0; ch < n; ch++) begin
               ch_level[ch]   = 1'b0;
               ch_count[ch]   = '0;
               ch_toggles[ch] = '0;
               m.driven[ch]   = 1'b1;
            end
         end
         default: ;
      endcase
      m.level = ch_level[MASK_W-1:0];
      return m;
   endfunction

   function automatic beep_cmd_type mk_cmd(input logic [OP_W-1:0] op, input int chan,
                                           input int reps, input int hi, input int lo);
      beep_cmd_type c;
      c.op   = op;
      c.chan = CHAN_W'(chan);
      c.reps = COUNT_W'(reps);
      c.hi   = COUNT_W'(hi);
      c.lo   = COUNT_W'(lo);
      return c;
   endfunction

   // Mostly ticks and well-formed rings with short periods and small counts so
   // patterns actually finish; a few long periods, forever rings, stops and
   // undefined codes mixed in. Unused fields carry random noise.
   function automatic beep_cmd_type rand_cmd();
      beep_cmd_type c;
      int pick;
      int r;
      c.chan = CHAN_W'($urandom);
      c.reps = COUNT_W'($urandom);
      c.hi   = COUNT_W'($urandom);
      c.lo   = COUNT_W'($urandom);
      pick   = $urandom_range(0, 99);
      if (pick < 62) begin
         c.op = OP_TICK;
      end else if (pick < 86) begin
         c.op = OP_RING;
         r = $urandom_range(0, 9);
         if (r == 0)
            c.reps = '0;
         else if (r == 1)
            c.reps = FOREVER_LIMIT;
         else if (r == 2)
            c.reps = COUNT_W'($urandom_range(101, 255));
         else
            c.reps = COUNT_W'($urandom_range(1, 3));
         c.hi = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(0, 3));
         c.lo = ($urandom_range(0, 19) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(0, 3));
      end else if (pick < 94) begin
         c.op = OP_STOP;
      end else begin
         c.op = OP_UNUSED;
      end
      return c;
   endfunction

   task automatic flag_mismatch(input string what, input logic [MASK_W-1:0] got,
                                input logic [MASK_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch @%0t: %s got %02h want %02h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Command sender: one item per call, optional idle burst in front.
   // Valid stays high between back-to-back items.
   // ---------------------------------------------------------------------
   task automatic send_cmd(input beep_cmd_type c);
      if (jitter_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= c.op;
      req_bus.channel      <= c.chan;
      req_bus.repeat_count <= c.reps;
      req_bus.high_ticks   <= c.hi;
      req_bus.low_ticks    <= c.lo;
      do @(posedge clock); while (!req_bus.ready);
      expected_masks.push_back(advance_channels(c));
      items_sent++;
      if (c.op == OP_RING) begin
         rings_sent++;
         if (c.reps > FOREVER_LIMIT)
            forever_rings++;
      end
   endtask

   // Lower valid and wait until every expected result is back, then wait on
   // so the block is surely idle. Leftovers are failures.
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      while (expected_masks.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (expected_masks.size() != 0) begin
         flag_mismatch("results never arrived, count", MASK_W'(expected_masks.size()), '0);
         expected_masks.delete();
      end
   endtask

   // Register writes happen only with the block idle.
   task automatic write_active(input logic [CSR_W-1:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      served_reg = value;
      csr_bus.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------------

   // Field extremes, every operation and the corner cases with all channels served.
   task automatic test_directed();
      // undefined code with every field bit set: only the level shows
      send_cmd(mk_cmd(OP_UNUSED, 7, 255, 255, 255));
      // zero count: loaded but idle
      send_cmd(mk_cmd(OP_RING, 0, 0, 0, 0));
      // forever ring, both periods 255: counter wraps and never toggles
      send_cmd(mk_cmd(OP_RING, 7, 255, 255, 255));
      send_cmd(mk_cmd(OP_RING, 1, 1, 0, 0));
      // 100 is the last finite count, 101 the first forever one
      send_cmd(mk_cmd(OP_RING, 2, 100, 0, 1));
      send_cmd(mk_cmd(OP_RING, 3, 101, 1, 0));
      // off period 255 holds the channel off
      send_cmd(mk_cmd(OP_RING, 4, 2, 0, 255));
      // on period 255: first tick goes high, then it stays high
      send_cmd(mk_cmd(OP_RING, 5, 1, 255, 0));
      repeat (8) send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0));
      send_cmd(mk_cmd(OP_STOP, 5, 170, 85, 170));
      send_cmd(mk_cmd(OP_TICK, 7, 255, 255, 255));
      send_cmd(mk_cmd(OP_UNUSED, 0, 0, 0, 0));
      // after the stop, ring channel 6 anew and run it to completion
      send_cmd(mk_cmd(OP_RING, 6, 1, 0, 0));
      repeat (3) send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0));
   endtask

   // Partial service: channels beyond the register setting load but never move.
   task automatic test_served_subset();
      write_active(4'd3);
      send_cmd(mk_cmd(OP_RING, 2, 2, 0, 0));
      send_cmd(mk_cmd(OP_RING, 5, 2, 0, 0));
      repeat (3) send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0));
      send_cmd(mk_cmd(OP_STOP, 0, 0, 0, 0));
      // nothing served: ticks and stop drive nothing
      write_active(4'd0);
      send_cmd(mk_cmd(OP_RING, 1, 1, 0, 0));
      repeat (2) send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0));
      send_cmd(mk_cmd(OP_STOP, 0, 0, 0, 0));
      // above the channel count acts as all channels; channel 5 resumes
      write_active(4'd15);
      repeat (4) send_cmd(mk_cmd(OP_TICK, 0, 0, 0, 0));
      send_cmd(mk_cmd(OP_STOP, 0, 0, 0, 0));
   endtask

   // Random traffic over several register settings with idle bursts on both sides.
   task automatic test_random_mix();
      logic [CSR_W-1:0] settings [4];
      settings = '{4'd15, 4'd1, 4'd6, 4'd8};
      jitter_on = 1'b1;
      foreach (settings[k]) begin
         write_active(settings[k]);
         for (int i = 0; i < 120; i++) begin
            // hold off once until the block has answered everything
            if (k == 1 && i == 60)
               wait_drained();
            send_cmd(rand_cmd());
         end
      end
   endtask

   // Last stretch at full rate, no idling on either side.
   task automatic test_quiet_tail();
      jitter_on = 1'b0;
      for (int i = 0; i < 60; i++)
         send_cmd(rand_cmd());
   endtask

   // ---------------------------------------------------------------------
   // Clock, watchdog, result checker
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * WATCHDOG_CYCLES);
      $display("timeout: %0d results still expected", expected_masks.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // Takes results with random stall bursts and compares each with the oldest
   // expectation, field by field.
   initial begin : result_checker
      int stall_left;
      beep_masks_type want;
      stall_left = 0;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_masks.size() == 0) begin
               flag_mismatch("unexpected result, level", rsp_bus.level_mask, '0);
            end else begin
               want = expected_masks.pop_front();
               results_checked++;
               finishes_seen += $countones(rsp_bus.finished_mask);
               if (rsp_bus.level_mask !== want.level)
                  flag_mismatch("level_mask", rsp_bus.level_mask, want.level);
               if (rsp_bus.driven_mask !== want.driven)
                  flag_mismatch("driven_mask", rsp_bus.driven_mask, want.driven);
               if (rsp_bus.finished_mask !== want.finished)
                  flag_mismatch("finished_mask", rsp_bus.finished_mask, want.finished);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (jitter_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.operation    <= OP_TICK;
      req_bus.channel      <= '0;
      req_bus.repeat_count <= '0;
      req_bus.high_ticks   <= '0;
      req_bus.low_ticks    <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.data         <= ACTIVE_RESET;
      clear_channels();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_served_subset();
      test_random_mix();
      test_quiet_tail();
      wait_drained();

      $display("covered %0d items (%0d rings, %0d forever), %0d results checked",
               items_sent, rings_sent, forever_rings, results_checked);
      $display("%0d channel finishes seen, active_channels set to 0, 1, 3, 6, 8, 15; %0d mismatches",
               finishes_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
